// ----- design/fpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int OP_W      = 4;
    localparam int SQRT_STEPS = 4;

    localparam logic [DATA_W-1:0] FIXED_ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] FRAC_MASK = FIXED_ONE - DATA_W'(1);
    localparam logic [DATA_W-1:0] FX_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] FX_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL    = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
    localparam logic [OP_W-1:0] OP_SQRT   = 4'd4;
    localparam logic [OP_W-1:0] OP_ABS    = 4'd5;
    localparam logic [OP_W-1:0] OP_MIN    = 4'd6;
    localparam logic [OP_W-1:0] OP_MAX    = 4'd7;
    localparam logic [OP_W-1:0] OP_SQUARE = 4'd8;
    localparam logic [OP_W-1:0] OP_FLOOR  = 4'd9;
    localparam logic [OP_W-1:0] OP_CEIL   = 4'd10;
    localparam logic [OP_W-1:0] OP_ROUND  = 4'd11;
    // unassigned codes, result is zero
    localparam logic [OP_W-1:0] OP_RSVD_LO = 4'd12;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 4'd15;

    // payload carried alongside the divider pipeline
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] res;
    } side_t;

endpackage
`default_nettype wire

// ----- design/fixed_point_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake              Payload
// input     start / busy           operation, operand_a, operand_b
// output    result_valid (strobe)  result
//
// Every operation passes the capture, simple-op and product-scaling registers;
// four chained bit-per-stage dividers serve divide and the square root steps.
// One transaction may enter every cycle; busy stays low.
// Reset clears only the valid bits; results leave in order, one strobe each.
module fixed_point_alu
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [fpa_pkg::OP_W-1:0]             operation,
    input  wire logic signed [fpa_pkg::DATA_W-1:0]    operand_a,
    input  wire logic signed [fpa_pkg::DATA_W-1:0]    operand_b,
    output logic                                      result_valid,
    output logic signed [fpa_pkg::DATA_W-1:0]         result
);

    localparam int DW = fpa_pkg::DATA_W;
    localparam int FB = fpa_pkg::FRAC_BITS;
    localparam int NS = fpa_pkg::SQRT_STEPS;

    // stage 1: capture
    logic                         v1_reg;
    logic [fpa_pkg::OP_W-1:0]     op1_reg;
    logic signed [DW-1:0]         a1_reg;
    logic signed [DW-1:0]         b1_reg;

    // stage 2: simple ops and product
    logic                         v2_reg;
    logic [fpa_pkg::OP_W-1:0]     op2_reg;
    logic signed [DW-1:0]         a2_reg;
    logic signed [DW-1:0]         b2_reg;
    logic signed [DW-1:0]         res2_reg;
    logic signed [DW-1:0]         res2_next;
    logic signed [2*DW-1:0]       prod2_reg;
    logic signed [DW-1:0]         mul_b;

    // stage 3: product scaling
    logic                         v3_reg;
    logic signed [DW-1:0]         b3_reg;
    fpa_pkg::side_t               side3_reg;
    fpa_pkg::side_t               side3_next;
    logic signed [2*DW-1:0]       prod_sh;

    logic signed [DW:0]           round_sum;
    logic signed [DW:0]           round_sh;

    // divider chain
    logic                         dv_in   [0:NS-1];
    logic signed [DW-1:0]         dden_in [0:NS-1];
    fpa_pkg::side_t               dside_in[0:NS-1];
    logic                         dv_out  [0:NS-1];
    logic signed [DW-1:0]         dq_out  [0:NS-1];
    fpa_pkg::side_t               dside_out[0:NS-1];
    logic                         pv_reg  [0:NS-1];
    fpa_pkg::side_t               pside_reg[0:NS-1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= operation;
        a1_reg  <= operand_a;
        b1_reg  <= operand_b;
    end

    assign mul_b     = (op1_reg == fpa_pkg::OP_SQUARE) ? a1_reg : b1_reg;
    assign round_sum = {a1_reg[DW-1], a1_reg} + (DW+1)'(fpa_pkg::FIXED_ONE >> 1);
    assign round_sh  = round_sum >>> FB;

    always_comb
    begin
        case (op1_reg)
            fpa_pkg::OP_ADD:   res2_next = a1_reg + b1_reg;
            fpa_pkg::OP_SUB:   res2_next = a1_reg - b1_reg;
            fpa_pkg::OP_ABS:   res2_next = a1_reg[DW-1] ? -a1_reg : a1_reg;
            fpa_pkg::OP_MIN:   res2_next = (a1_reg < b1_reg) ? a1_reg : b1_reg;
            fpa_pkg::OP_MAX:   res2_next = (a1_reg < b1_reg) ? b1_reg : a1_reg;
            fpa_pkg::OP_FLOOR: res2_next = a1_reg & ~fpa_pkg::FRAC_MASK;
            fpa_pkg::OP_CEIL:  res2_next = (a1_reg + fpa_pkg::FRAC_MASK) & ~fpa_pkg::FRAC_MASK;
            fpa_pkg::OP_ROUND: res2_next = round_sh[DW-1:0];
            default:           res2_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        op2_reg   <= op1_reg;
        a2_reg    <= a1_reg;
        b2_reg    <= b1_reg;
        res2_reg  <= res2_next;
        prod2_reg <= a1_reg * mul_b;
    end

    assign prod_sh = prod2_reg >>> FB;

    always_comb
    begin
        side3_next.op = op2_reg;
        side3_next.a  = a2_reg;
        case (op2_reg)
            fpa_pkg::OP_MUL,
            fpa_pkg::OP_SQUARE: side3_next.res = prod_sh[DW-1:0];
            fpa_pkg::OP_SQRT:   side3_next.res = fpa_pkg::FIXED_ONE;
            default:            side3_next.res = res2_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        side3_reg <= side3_next;
        b3_reg    <= b2_reg;
    end

    for (genvar i = 0; i < NS; i++) begin : g_newton
        logic signed [DW:0]   sum;
        fpa_pkg::side_t       post_next;

        if (i == 0) begin : g_first
            always_comb
            begin
                dv_in[i]    = v3_reg;
                dside_in[i] = side3_reg;
                dden_in[i]  = (side3_reg.op == fpa_pkg::OP_SQRT) ? side3_reg.res : b3_reg;
            end
        end
        else begin : g_rest
            always_comb
            begin
                dv_in[i]    = pv_reg[i-1];
                dside_in[i] = pside_reg[i-1];
                dden_in[i]  = pside_reg[i-1].res;
            end
        end

        fpa_div u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (dv_in[i]),
            .num      (dside_in[i].a),
            .den      (dden_in[i]),
            .side_in  (dside_in[i]),
            .vld_out  (dv_out[i]),
            .quo      (dq_out[i]),
            .side_out (dside_out[i])
        );

        // Newton update: x = floor((x + n / x) / 2); stage 0 passes a divide's quotient
        always_comb
        begin
            sum       = {dq_out[i][DW-1], dq_out[i]}
                      + {dside_out[i].res[DW-1], dside_out[i].res};
            post_next = dside_out[i];
            if (dside_out[i].op == fpa_pkg::OP_SQRT)
            begin
                if ((i == NS - 1) && (dside_out[i].a <= 0))
                    post_next.res = '0;
                else
                    post_next.res = sum[DW:1];
            end
            else if ((i == 0) && (dside_out[i].op == fpa_pkg::OP_DIV))
                post_next.res = dq_out[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pv_reg[i] <= 1'b0;
            else
                pv_reg[i] <= dv_out[i];
        end

        always_ff @(posedge clk)
        begin
            pside_reg[i] <= post_next;
        end
    end

    assign result_valid = pv_reg[NS-1];
    assign result       = pside_reg[NS-1].res;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_sqrt_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (pside_reg[NS-1].op == fpa_pkg::OP_SQRT)
            && (pside_reg[NS-1].a <= 0) |-> (result == '0))
        else $error("square root of non-positive value not zero");

    a_chain_flow: assert property (@(posedge clk) disable iff (!rst_n)
        dv_out[NS-1] |=> result_valid)
        else $error("transaction lost at the last Newton stage");

endmodule
`default_nettype wire

// ----- design/fpa_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fpa_div
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                vld_in,
    input  wire logic signed [fpa_pkg::DATA_W-1:0]   num,
    input  wire logic signed [fpa_pkg::DATA_W-1:0]   den,
    input  wire fpa_pkg::side_t                      side_in,
    output logic                                     vld_out,
    output logic signed [fpa_pkg::DATA_W-1:0]       quo,
    output fpa_pkg::side_t                           side_out
);

    localparam int NW = fpa_pkg::NUM_W;
    localparam int DW = fpa_pkg::DATA_W;

    logic              vld_reg  [0:NW];
    logic [NW-1:0]     dq_reg   [0:NW];
    logic [DW-1:0]     rem_reg  [0:NW];
    logic [DW-1:0]     d_reg    [0:NW];
    logic              neg_reg  [0:NW];
    logic              zero_reg [0:NW];
    logic              aneg_reg [0:NW];
    fpa_pkg::side_t    side_reg [0:NW];

    logic              fin_vld_reg;
    logic [DW-1:0]     fin_q_reg;
    fpa_pkg::side_t    fin_side_reg;

    logic [DW-1:0]     abs_num;
    logic [DW-1:0]     abs_den;
    logic [NW-1:0]     q_signed;
    logic [DW-1:0]     fin_q_next;

    assign abs_num = num[DW-1] ? DW'(-num) : num;
    assign abs_den = den[DW-1] ? DW'(-den) : den;

    // prepare magnitudes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        dq_reg[0]   <= {abs_num, {fpa_pkg::FRAC_BITS{1'b0}}};
        rem_reg[0]  <= '0;
        d_reg[0]    <= abs_den;
        neg_reg[0]  <= num[DW-1] ^ den[DW-1];
        zero_reg[0] <= (den == '0);
        aneg_reg[0] <= num[DW-1];
        side_reg[0] <= side_in;
    end

    // one quotient bit per stage
    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [DW:0]   rem_sh;
        logic          ge;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            rem_sh   = {rem_reg[k], dq_reg[k][NW-1]};
            ge       = rem_sh >= {1'b0, d_reg[k]};
            rem_next = ge ? DW'(rem_sh - {1'b0, d_reg[k]}) : rem_sh[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dq_reg[k+1]   <= {dq_reg[k][NW-2:0], ge};
            rem_reg[k+1]  <= rem_next;
            d_reg[k+1]    <= d_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            zero_reg[k+1] <= zero_reg[k];
            aneg_reg[k+1] <= aneg_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    // apply sign, keep low word, saturate on zero divisor
    always_comb
    begin
        q_signed = neg_reg[NW] ? NW'(-dq_reg[NW]) : dq_reg[NW];
        if (zero_reg[NW])
            fin_q_next = aneg_reg[NW] ? fpa_pkg::FX_MIN : fpa_pkg::FX_MAX;
        else
            fin_q_next = q_signed[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_vld_reg <= 1'b0;
        else
            fin_vld_reg <= vld_reg[NW];
    end

    always_ff @(posedge clk)
    begin
        fin_q_reg    <= fin_q_next;
        fin_side_reg <= side_reg[NW];
    end

    assign vld_out  = fin_vld_reg;
    assign quo      = fin_q_reg;
    assign side_out = fin_side_reg;

    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NW] && zero_reg[NW] |=>
            (fin_q_reg == fpa_pkg::FX_MAX) || (fin_q_reg == fpa_pkg::FX_MIN))
        else $error("zero divisor did not saturate");

    a_zero_neg: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NW] && zero_reg[NW] && aneg_reg[NW] |=> (fin_q_reg == fpa_pkg::FX_MIN))
        else $error("negative dividend over zero did not saturate low");

    a_vld_flow: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NW] |=> fin_vld_reg)
        else $error("divider dropped a transaction");

endmodule
`default_nettype wire

// ----- bench/fpa_checker.sv -----
`timescale 1ns / 1ps
module fpa_checker
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic [fpa_pkg::OP_W-1:0]          operation,
    input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_a,
    input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_b,
    input  wire logic                              result_valid,
    input  wire logic signed [fpa_pkg::DATA_W-1:0] result,
    output int                                     fail_count,
    output int                                     pending
);

    localparam int DW = fpa_pkg::DATA_W;
    localparam int FB = fpa_pkg::FRAC_BITS;

    logic signed [DW-1:0] expected_results[$];

    function automatic logic signed [DW-1:0] fx_mul(logic signed [DW-1:0] x,
                                                    logic signed [DW-1:0] y);
        logic signed [63:0] p;
        p = 64'(x) * 64'(y);
        return DW'(p >>> FB);
    endfunction

    function automatic logic signed [DW-1:0] fx_div(logic signed [DW-1:0] x,
                                                    logic signed [DW-1:0] y);
        logic signed [63:0] num;
        logic signed [63:0] q;
        if (y == 0)
            return (x >= 0) ? fpa_pkg::FX_MAX : fpa_pkg::FX_MIN;
        num = 64'(x) <<< FB;
        q = num / 64'(y);
        return DW'(q);
    endfunction

    function automatic logic signed [DW-1:0] fx_sqrt(logic signed [DW-1:0] n);
        logic signed [DW-1:0] x;
        logic signed [63:0] s;
        x = fpa_pkg::FIXED_ONE;
        if (n <= 0)
            return '0;
        for (int i = 0; i < fpa_pkg::SQRT_STEPS; i++)
        begin
            s = 64'(x) + 64'(fx_div(n, x));
            x = DW'(s >>> 1);
        end
        return x;
    endfunction

    function automatic logic signed [DW-1:0] alu_result(logic [fpa_pkg::OP_W-1:0] op,
                                                        logic signed [DW-1:0] a,
                                                        logic signed [DW-1:0] b);
        logic signed [63:0] r64;
        case (op)
            fpa_pkg::OP_ADD:    return a + b;
            fpa_pkg::OP_SUB:    return a - b;
            fpa_pkg::OP_MUL:    return fx_mul(a, b);
            fpa_pkg::OP_DIV:    return fx_div(a, b);
            fpa_pkg::OP_SQRT:   return fx_sqrt(a);
            fpa_pkg::OP_ABS:    return (a < 0) ? -a : a;
            fpa_pkg::OP_MIN:    return (a < b) ? a : b;
            fpa_pkg::OP_MAX:    return (a < b) ? b : a;
            fpa_pkg::OP_SQUARE: return fx_mul(a, a);
            fpa_pkg::OP_FLOOR:  return a & ~fpa_pkg::FRAC_MASK;
            fpa_pkg::OP_CEIL:   return (a + fpa_pkg::FRAC_MASK) & ~fpa_pkg::FRAC_MASK;
            fpa_pkg::OP_ROUND:
            begin
                r64 = 64'(a) + (64'sd1 <<< (FB - 1));
                return DW'(r64 >>> FB);
            end
            default:            return '0;
        endcase
    endfunction

    assign pending = expected_results.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (result !== expected_results[0])
                    begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, expected_results[0], result);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (start && !busy)
                expected_results.push_back(alu_result(operation, operand_a, operand_b));
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

    localparam int DW = fpa_pkg::DATA_W;
    localparam int FB = fpa_pkg::FRAC_BITS;
    localparam int LATENCY = 3 + fpa_pkg::SQRT_STEPS * (fpa_pkg::NUM_W + 3);

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [fpa_pkg::OP_W-1:0]     operation = fpa_pkg::OP_ADD;
    logic signed [DW-1:0]         operand_a = '0;
    logic signed [DW-1:0]         operand_b = '0;
    logic                         result_valid;
    logic signed [DW-1:0]         result;
    int                           fail_count;
    int                           pending;
    int                           idle_pct;
    int                           op_count[16];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    fixed_point_alu i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .operand_a(operand_a), .operand_b(operand_b),
        .result_valid(result_valid), .result(result)
    );

    fpa_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .operand_a(operand_a), .operand_b(operand_b),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    // Drive one transaction, inserting random idle cycles, and hold until accepted.
    task automatic issue_op(logic [fpa_pkg::OP_W-1:0] op, logic signed [DW-1:0] a,
                            logic signed [DW-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        operand_a <= a;
        operand_b <= b;
        op_count[op]++;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic signed [DW-1:0] pick_operand();
        case ($urandom_range(7))
            0: return fpa_pkg::FX_MAX - $urandom_range(3);
            1: return fpa_pkg::FX_MIN + $urandom_range(3);
            2: return $signed(DW'($urandom_range(8))) << FB;
            3: return -($signed(DW'($urandom_range(8))) << FB);
            4: return $signed(DW'($urandom_range(1 << (FB + 4))))
                      - (1 <<< (FB + 3));
            5: return '0;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [fpa_pkg::OP_W-1:0] op;
        int unused_count;
        idle_pct = 0;
        unused_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_op(fpa_pkg::OP_ADD, fpa_pkg::FX_MAX, 32'sd1);
        issue_op(fpa_pkg::OP_SUB, fpa_pkg::FX_MIN, 32'sd1);
        issue_op(fpa_pkg::OP_MUL, fpa_pkg::FX_MAX, fpa_pkg::FX_MAX);
        issue_op(fpa_pkg::OP_MUL, fpa_pkg::FX_MIN, -32'sd1);
        issue_op(fpa_pkg::OP_DIV, 32'sd5 <<< FB, 32'sd0);
        issue_op(fpa_pkg::OP_DIV, -32'sd5, 32'sd0);
        issue_op(fpa_pkg::OP_DIV, fpa_pkg::FX_MAX, 32'sd1);
        issue_op(fpa_pkg::OP_DIV, -32'sd7 <<< FB, 32'sd2 <<< FB);
        issue_op(fpa_pkg::OP_SQRT, 32'sd0, '0);
        issue_op(fpa_pkg::OP_SQRT, fpa_pkg::FX_MIN, '0);
        issue_op(fpa_pkg::OP_SQRT, fpa_pkg::FX_MAX, '0);
        issue_op(fpa_pkg::OP_SQRT, 32'sd4 <<< FB, '0);
        issue_op(fpa_pkg::OP_ABS, fpa_pkg::FX_MIN, '0);
        issue_op(fpa_pkg::OP_ABS, -32'sd3, '0);
        issue_op(fpa_pkg::OP_MIN, fpa_pkg::FX_MIN, fpa_pkg::FX_MAX);
        issue_op(fpa_pkg::OP_MAX, fpa_pkg::FX_MIN, fpa_pkg::FX_MAX);
        issue_op(fpa_pkg::OP_SQUARE, fpa_pkg::FX_MIN, '0);
        issue_op(fpa_pkg::OP_FLOOR, -32'sd1, '0);
        issue_op(fpa_pkg::OP_CEIL, fpa_pkg::FX_MAX, '0);
        issue_op(fpa_pkg::OP_CEIL, -32'sd1, '0);
        issue_op(fpa_pkg::OP_ROUND, fpa_pkg::FX_MAX, '0);
        issue_op(fpa_pkg::OP_ROUND, -32'sd32768, '0);
        issue_op(fpa_pkg::OP_RSVD_LO, 32'sd1, 32'sd1);
        issue_op(fpa_pkg::OP_RSVD_HI, -32'sd1, -32'sd1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 59;
                2: idle_pct = 9;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 200; n++)
            begin
                op = ($urandom_range(19) == 0)
                   ? fpa_pkg::OP_W'($urandom_range(int'(fpa_pkg::OP_RSVD_HI),
                                                   int'(fpa_pkg::OP_RSVD_LO)))
                   : fpa_pkg::OP_W'($urandom_range(int'(fpa_pkg::OP_ROUND)));
                issue_op(op, pick_operand(), pick_operand());
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        for (int c = int'(fpa_pkg::OP_RSVD_LO); c <= int'(fpa_pkg::OP_RSVD_HI); c++)
            unused_count += op_count[c];

        $display("Covered operations: add %0d sub %0d mul %0d div %0d sqrt %0d abs %0d",
                 op_count[fpa_pkg::OP_ADD], op_count[fpa_pkg::OP_SUB],
                 op_count[fpa_pkg::OP_MUL], op_count[fpa_pkg::OP_DIV],
                 op_count[fpa_pkg::OP_SQRT], op_count[fpa_pkg::OP_ABS]);
        $display("  min %0d max %0d square %0d floor %0d ceil %0d round %0d unused %0d",
                 op_count[fpa_pkg::OP_MIN], op_count[fpa_pkg::OP_MAX],
                 op_count[fpa_pkg::OP_SQUARE], op_count[fpa_pkg::OP_FLOOR],
                 op_count[fpa_pkg::OP_CEIL], op_count[fpa_pkg::OP_ROUND], unused_count);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
